### hdl/iptf_pkg.sv
// ----------------------------------------------------------------------------
// IPv4 prefix trie filter package
// Shared types and constants for the prefix trie filter unit.
// ----------------------------------------------------------------------------
package iptf_pkg;

   localparam int ADDR_BITS = 32;
   localparam int LEVEL_W   = 6;

   localparam logic [1:0] MODE_LOOKUP    = 2'd0;
   localparam logic [1:0] MODE_INSERT    = 2'd1;
   localparam int         MODE_CLEAR_BIT = 1;

   typedef enum logic [2:0] {
      ST_NOMATCH  = 3'd0,
      ST_MATCH    = 3'd1,
      ST_EMPTY    = 3'd2,
      ST_ENDED    = 3'd3,
      ST_INSERTED = 3'd4,
      ST_FULL     = 3'd5,
      ST_CLEARED  = 3'd6
   } status_type;

   typedef struct packed {
      logic [1:0]           mode;
      logic [ADDR_BITS-1:0] address;
      logic [LEVEL_W-1:0]   prefix_length;
   } req_type;

   typedef struct packed {
      status_type         status;
      logic [LEVEL_W-1:0] nodes_added;
   } rsp_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_LOOKUP_WALK,
      S_INSERT_WALK,
      S_INSERT_CHECK,
      S_INSERT_WRITE
   } state_type;

   typedef struct packed {
      logic       load;
      logic       read_root;
      logic       walk_step;
      logic       hold_node;
      logic       commit;
      logic       write_node;
      logic       clear_table;
      logic       rsp_load;
      status_type rsp_status;
   } ctl_cmd_type;

   typedef struct packed {
      logic root_present;
      logic node_mark;
      logic child_zero;
      logic level_full;
      logic at_prefix_end;
      logic fits;
   } dp_status_type;

endpackage

### hdl/iptf_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
module iptf_ram #(
   parameter int WIDTH = 21,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/iptf_ctrl.sv
// ----------------------------------------------------------------------------
// Prefix trie filter controller
// Sequences clears, lookup walks, insert walk, capacity check and node writes.
// ----------------------------------------------------------------------------
module iptf_ctrl
   import iptf_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [1:0]    req_mode,
   input  dp_status_type dp_status,
   output ctl_cmd_type   cmd,
   output logic          busy
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      cmd            = '0;
      cmd.rsp_status = ST_NOMATCH;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               priority if (req_mode[MODE_CLEAR_BIT]) begin
                  cmd.clear_table = 1'b1;
                  cmd.rsp_load    = 1'b1;
                  cmd.rsp_status  = ST_CLEARED;
               end else if (req_mode == MODE_INSERT) begin
                  if (dp_status.root_present) begin
                     cmd.read_root = 1'b1;
                     state_in      = S_INSERT_WALK;
                  end else begin
                     state_in = S_INSERT_CHECK;
                  end
               end else begin
                  if (dp_status.root_present) begin
                     cmd.read_root = 1'b1;
                     state_in      = S_LOOKUP_WALK;
                  end else begin
                     cmd.rsp_load   = 1'b1;
                     cmd.rsp_status = ST_EMPTY;
                  end
               end
            end
         end
         S_LOOKUP_WALK: begin
            // The mark of the node just read wins over every other outcome.
            priority if (dp_status.node_mark) begin
               cmd.rsp_load   = 1'b1;
               cmd.rsp_status = ST_MATCH;
               state_in       = S_IDLE;
            end else if (dp_status.level_full) begin
               cmd.rsp_load   = 1'b1;
               cmd.rsp_status = ST_NOMATCH;
               state_in       = S_IDLE;
            end else if (dp_status.child_zero) begin
               cmd.rsp_load   = 1'b1;
               cmd.rsp_status = ST_ENDED;
               state_in       = S_IDLE;
            end else begin
               cmd.walk_step = 1'b1;
            end
         end
         S_INSERT_WALK: begin
            if (dp_status.at_prefix_end || dp_status.child_zero) begin
               cmd.hold_node = 1'b1;
               state_in      = S_INSERT_CHECK;
            end else begin
               cmd.walk_step = 1'b1;
            end
         end
         S_INSERT_CHECK: begin
            if (dp_status.fits) begin
               cmd.commit = 1'b1;
               state_in   = S_INSERT_WRITE;
            end else begin
               cmd.rsp_load   = 1'b1;
               cmd.rsp_status = ST_FULL;
               state_in       = S_IDLE;
            end
         end
         S_INSERT_WRITE: begin
            cmd.write_node = 1'b1;
            if (dp_status.at_prefix_end) begin
               cmd.rsp_load   = 1'b1;
               cmd.rsp_status = ST_INSERTED;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != S_IDLE);

endmodule

### hdl/iptf_datapath.sv
// ----------------------------------------------------------------------------
// Prefix trie filter datapath
// Node memory, walk registers, node pool counter and result register.
// ----------------------------------------------------------------------------
module iptf_datapath
   import iptf_pkg::*;
#(
   parameter int NODE_COUNT = 1024
) (
   input  logic          clock,
   input  logic          reset,
   input  req_type       req_data,
   input  ctl_cmd_type   cmd,
   output dp_status_type dp_status,
   output logic          rsp_strobe,
   output rsp_type       rsp_data
);

   localparam int IDX_W  = $clog2(NODE_COUNT);
   localparam int CNT_W  = $clog2(NODE_COUNT + 1);
   localparam int SUM_W  = CNT_W + 1;
   localparam int NODE_W = 2 * IDX_W + 1;

   logic [ADDR_BITS-1:0] addr_ff, addr_in;
   logic [LEVEL_W-1:0]   plen_ff, plen_in;
   logic [LEVEL_W-1:0]   lvl_ff, lvl_in;
   logic [LEVEL_W-1:0]   needed_ff, needed_in;
   logic [IDX_W-1:0]     cur_ff, cur_in;
   logic [NODE_W-1:0]    held_ff, held_in;
   logic [CNT_W-1:0]     free_ff, free_in;
   logic                 root_ff, root_in;
   rsp_type              rsp_ff, rsp_in;
   logic                 strobe_ff, strobe_in;

   logic [NODE_W-1:0]    rd_data;
   logic [NODE_W-1:0]    wr_data;
   logic [IDX_W-1:0]     rd_addr;
   logic [IDX_W-1:0]     child0;
   logic [IDX_W-1:0]     child1;
   logic [IDX_W-1:0]     sel_child;
   logic [IDX_W-1:0]     new_idx;
   logic [LEVEL_W-1:0]   needed;
   logic [SUM_W-1:0]     pool_sum;
   logic                 cur_bit;
   logic                 at_end;

   // Node layout: mark, child for bit one, child for bit zero.
   assign child0    = rd_data[IDX_W-1:0];
   assign child1    = rd_data[2*IDX_W-1:IDX_W];
   assign cur_bit   = addr_ff[ADDR_BITS-1];
   assign sel_child = cur_bit ? child1 : child0;
   assign new_idx   = free_ff[IDX_W-1:0];
   assign at_end    = (lvl_ff == plen_ff);
   assign rd_addr   = cmd.walk_step ? sel_child : '0;

   assign needed   = root_ff ? LEVEL_W'(plen_ff - lvl_ff) : LEVEL_W'(plen_ff + LEVEL_W'(1));
   assign pool_sum = SUM_W'(free_ff) + SUM_W'(needed);

   always_comb begin
      wr_data = held_ff;
      if (at_end) begin
         wr_data[NODE_W-1] = 1'b1;
      end else if (cur_bit) begin
         wr_data[2*IDX_W-1:IDX_W] = new_idx;
      end else begin
         wr_data[IDX_W-1:0] = new_idx;
      end
   end

   iptf_ram #(
      .WIDTH(NODE_W),
      .DEPTH(NODE_COUNT)
   ) u_node_ram (
      .clock  (clock),
      .wr_en  (cmd.write_node),
      .wr_addr(cur_ff),
      .wr_data(wr_data),
      .rd_en  (cmd.read_root | cmd.walk_step),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   always_comb begin
      addr_in   = addr_ff;
      plen_in   = plen_ff;
      lvl_in    = lvl_ff;
      needed_in = needed_ff;
      cur_in    = cur_ff;
      held_in   = held_ff;
      free_in   = free_ff;
      root_in   = root_ff;
      rsp_in    = rsp_ff;
      strobe_in = cmd.rsp_load;

      if (cmd.load) begin
         addr_in = req_data.address;
         plen_in = (req_data.prefix_length > LEVEL_W'(ADDR_BITS)) ?
                   LEVEL_W'(ADDR_BITS) : req_data.prefix_length;
         lvl_in  = '0;
         cur_in  = '0;
      end
      if (cmd.walk_step) begin
         cur_in  = sel_child;
         lvl_in  = LEVEL_W'(lvl_ff + LEVEL_W'(1));
         addr_in = addr_ff << 1;
      end
      if (cmd.hold_node) begin
         held_in = rd_data;
      end
      if (cmd.commit) begin
         needed_in = needed;
         // An empty table takes the root from the pool first.
         if (!root_ff) begin
            cur_in  = '0;
            lvl_in  = '0;
            held_in = '0;
            free_in = CNT_W'(1);
            root_in = 1'b1;
         end
      end
      if (cmd.write_node && !at_end) begin
         cur_in  = new_idx;
         lvl_in  = LEVEL_W'(lvl_ff + LEVEL_W'(1));
         addr_in = addr_ff << 1;
         held_in = '0;
         free_in = CNT_W'(free_ff + CNT_W'(1));
      end
      if (cmd.clear_table) begin
         free_in = '0;
         root_in = 1'b0;
      end
      if (cmd.rsp_load) begin
         rsp_in.status      = cmd.rsp_status;
         rsp_in.nodes_added = (cmd.rsp_status == ST_INSERTED) ? needed_ff : '0;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff   <= addr_in;
      plen_ff   <= plen_in;
      lvl_ff    <= lvl_in;
      needed_ff <= needed_in;
      cur_ff    <= cur_in;
      held_ff   <= held_in;
      rsp_ff    <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         free_ff   <= '0;
         root_ff   <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         free_ff   <= free_in;
         root_ff   <= root_in;
         strobe_ff <= strobe_in;
      end
   end

   assign dp_status.root_present  = root_ff;
   assign dp_status.node_mark     = rd_data[NODE_W-1];
   assign dp_status.child_zero    = (sel_child == '0);
   assign dp_status.level_full    = (lvl_ff == LEVEL_W'(ADDR_BITS));
   assign dp_status.at_prefix_end = at_end;
   assign dp_status.fits          = (SUM_W'(free_ff) <= SUM_W'(NODE_COUNT)) &&
                                    (pool_sum <= SUM_W'(NODE_COUNT));

   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

### hdl/ipv4_prefix_trie_filter_unit.sv
// ----------------------------------------------------------------------------
// IPv4 prefix trie filter unit
// Binary trie over IPv4 addresses in a node memory: lookup, insert, clear.
// ----------------------------------------------------------------------------
//  Channel   Ports                    Transfer when
//  request   start, busy, req_data    start high while busy is low
//  response  rsp_strobe, rsp_data     every cycle rsp_strobe is high
//
// Clear, and a lookup on an empty table, finish in the accept cycle. A lookup
// reads the trie one level at a time; an insert walks the levels already
// present, then runs a capacity check and one node write per level. The
// result strobe is registered and rises in the cycle after, when busy is
// already low. Reset empties the table; the receiver cannot stall.
// ----------------------------------------------------------------------------
module ipv4_prefix_trie_filter_unit
   import iptf_pkg::*;
#(
   parameter int NODE_COUNT = 1024
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);

   ctl_cmd_type   cmd;
   dp_status_type dp_status;

   iptf_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_mode (req_data.mode),
      .dp_status(dp_status),
      .cmd      (cmd),
      .busy     (busy)
   );

   iptf_datapath #(
      .NODE_COUNT(NODE_COUNT)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .dp_status (dp_status),
      .rsp_strobe(rsp_strobe),
      .rsp_data  (rsp_data)
   );

`ifndef SYNTHESIS
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_strobe))
      else $error("accepted request neither started nor answered");

   a_result_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result shown while controller busy");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.status == ST_CLEARED) |-> !dp_status.root_present)
      else $error("table still holds a root after clear");

   a_count_only_insert: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.status != ST_INSERTED) |-> (rsp_data.nodes_added == '0))
      else $error("node count reported outside an insert");
`endif

endmodule

### bench/iptf_result_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Prefix trie filter result checker
// Watches the request and response channels of the trie filter unit, keeps
// its own copy of the trie, predicts the outcome of every accepted transfer
// and compares each strobed response with the oldest prediction.
// ----------------------------------------------------------------------------
module iptf_result_checker
   import iptf_pkg::*;
#(
   parameter int NODE_COUNT = 1024
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  logic    busy,
   input  req_type req_data,
   input  logic    rsp_strobe,
   input  rsp_type rsp_data,
   output int      error_count,
   output int      pending
);

   int trie_child [NODE_COUNT][2];
   bit trie_mark  [NODE_COUNT];
   int pool_next;
   bit table_live;

   rsp_type predicted_outcomes[$];

   // Hands out the next pool entry with no children and no mark.
   function automatic int claim_node();
      int idx;
      idx = pool_next;
      trie_child[idx][0] = 0;
      trie_child[idx][1] = 0;
      trie_mark[idx]     = 1'b0;
      pool_next++;
      return idx;
   endfunction

   function automatic rsp_type apply_trie_op(req_type item);
      rsp_type outcome;
      int      plen;
      int      depth;
      int      needed;
      int      cur;
      int      nxt;
      int      lvl;
      bit      b;
      outcome.status      = ST_CLEARED;
      outcome.nodes_added = '0;
      if (item.mode[MODE_CLEAR_BIT]) begin
         pool_next  = 0;
         table_live = 1'b0;
         return outcome;
      end
      if (item.mode == MODE_INSERT) begin
         plen = (item.prefix_length > ADDR_BITS) ? ADDR_BITS : int'(item.prefix_length);
         if (!table_live) begin
            needed = plen + 1;
         end else begin
            depth = 0;
            cur   = 0;
            while (depth < plen) begin
               nxt = trie_child[cur][item.address[ADDR_BITS-1-depth]];
               if (nxt == 0) break;
               cur = nxt;
               depth++;
            end
            needed = plen - depth;
         end
         // The whole path must fit, otherwise the table is left untouched.
         if (needed > NODE_COUNT - pool_next) begin
            outcome.status = ST_FULL;
            return outcome;
         end
         if (!table_live) begin
            pool_next = 0;
            void'(claim_node());
            table_live = 1'b1;
         end
         cur = 0;
         for (lvl = 0; lvl < plen; lvl++) begin
            b   = item.address[ADDR_BITS-1-lvl];
            nxt = trie_child[cur][b];
            if (nxt == 0) begin
               nxt = claim_node();
               trie_child[cur][b] = nxt;
            end
            cur = nxt;
         end
         trie_mark[cur]      = 1'b1;
         outcome.status      = ST_INSERTED;
         outcome.nodes_added = LEVEL_W'(needed);
         return outcome;
      end
      if (!table_live) begin
         outcome.status = ST_EMPTY;
         return outcome;
      end
      cur = 0;
      for (lvl = 0; lvl < ADDR_BITS; lvl++) begin
         if (trie_mark[cur]) begin
            outcome.status = ST_MATCH;
            return outcome;
         end
         cur = trie_child[cur][item.address[ADDR_BITS-1-lvl]];
         if (cur == 0) begin
            outcome.status = ST_ENDED;
            return outcome;
         end
      end
      outcome.status = trie_mark[cur] ? ST_MATCH : ST_NOMATCH;
      return outcome;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         pool_next  = 0;
         table_live = 1'b0;
         predicted_outcomes.delete();
      end else begin
         // A response always comes after its own transfer, so it is matched
         // before a transfer at the same edge is added.
         if (rsp_strobe) begin
            if (predicted_outcomes.size() == 0) begin
               $error("response with no transfer outstanding: status %0d nodes_added %0d",
                      rsp_data.status, rsp_data.nodes_added);
               error_count++;
            end else begin
               want = predicted_outcomes.pop_front();
               if (rsp_data.status !== want.status) begin
                  $error("status: expected %0d actual %0d", want.status, rsp_data.status);
                  error_count++;
               end
               if (rsp_data.nodes_added !== want.nodes_added) begin
                  $error("nodes_added: expected %0d actual %0d",
                         want.nodes_added, rsp_data.nodes_added);
                  error_count++;
               end
            end
         end
         if (start && !busy) begin
            predicted_outcomes.push_back(apply_trie_op(req_data));
         end
      end
      pending = predicted_outcomes.size();
   end

endmodule

### bench/ipv4_prefix_trie_filter_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Prefix trie filter unit testbench
// Drives lookups, inserts and clears into the trie filter unit: a directed
// opening, then rounds that fill the node pool to exhaustion and rounds of
// mixed traffic aimed at stored prefixes. A separate checker predicts and
// compares every response; this module gives the verdict.
// ----------------------------------------------------------------------------
module ipv4_prefix_trie_filter_unit_tb;
   import iptf_pkg::*;

   localparam int NODE_COUNT = 1024;
   localparam int ITEM_GOAL  = 920;
   localparam int QUIET_FROM = 830;

   localparam logic [1:0] MODE_CLEAR = 2'(1 << MODE_CLEAR_BIT);
   localparam logic [1:0] MODE_SPARE = MODE_CLEAR | MODE_INSERT;

   logic    clock = 1'b0;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_strobe;
   rsp_type rsp_data;

   int failures;
   int outstanding;

   int          items_sent;
   bit          idle_enabled;
   logic [31:0] known_addrs[$];

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   ipv4_prefix_trie_filter_unit #(.NODE_COUNT(NODE_COUNT)) dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   iptf_result_checker #(.NODE_COUNT(NODE_COUNT)) outcome_check (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_data    (req_data),
      .rsp_strobe  (rsp_strobe),
      .rsp_data    (rsp_data),
      .error_count (failures),
      .pending     (outstanding)
   );

   function automatic req_type make_req(logic [1:0] m, logic [31:0] a, logic [5:0] p);
      req_type r;
      r.mode          = m;
      r.address       = a;
      r.prefix_length = p;
      return r;
   endfunction

   // Mostly an address close to a stored prefix, so that walks go deep.
   function automatic logic [31:0] near_addr();
      logic [31:0] base;
      logic [31:0] mask;
      int          k;
      if (known_addrs.size() > 0 && $urandom_range(0, 3) != 0)
         base = known_addrs[$urandom_range(0, known_addrs.size() - 1)];
      else
         base = $urandom;
      k    = $urandom_range(0, 32);
      mask = (k == 32) ? '1 : (32'd1 << k) - 32'd1;
      return base ^ ($urandom & mask);
   endfunction

   task automatic send(req_type item);
      int gap;
      if (idle_enabled && items_sent < QUIET_FROM && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 3);
         @(negedge clock);
         start    <= 1'b0;
         req_data <= make_req(2'($urandom), $urandom, 6'($urandom));
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      start    <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (busy);
      items_sent++;
   endtask

   task automatic send_clear();
      known_addrs.delete();
      send(make_req($urandom_range(0, 1) ? MODE_SPARE : MODE_CLEAR, $urandom, 6'($urandom)));
   endtask

   task automatic send_insert(logic [31:0] a, logic [5:0] p);
      known_addrs.push_back(a);
      send(make_req(MODE_INSERT, a, p));
   endtask

   task automatic send_lookup(logic [31:0] a);
      send(make_req(MODE_LOOKUP, a, 6'($urandom)));
   endtask

   initial begin
      #1_000_000;
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      int r;
      int p;
      reset        = 1'b1;
      start        = 1'b0;
      req_data     = '0;
      items_sent   = 0;
      idle_enabled = 1'b1;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed opening.
      send_lookup(32'h0000_0000);
      send_insert(32'hC0A8_0000, 6'd16);
      send_lookup(32'hC0A8_1234);
      send_lookup(32'hC0A9_0000);
      send_lookup(32'h0000_0000);
      send_insert(32'hC0A8_0000, 6'd16);
      send_insert(32'hFFFF_FFFF, 6'd63);
      send_lookup(32'hFFFF_FFFF);
      send_lookup(32'hFFFF_FFFE);
      send_insert(32'h0000_0000, 6'd32);
      send_lookup(32'h0000_0000);
      send_lookup(32'h0000_0001);
      send(make_req(MODE_CLEAR, 32'hFFFF_FFFF, 6'd63));
      send_lookup(32'h0A00_0001);
      send_insert(32'h0A00_0000, 6'd8);
      send_insert(32'h1234_5678, 6'd0);
      send_lookup(32'h5555_5555);
      send(make_req(MODE_SPARE, 32'h0000_0000, 6'd0));
      send_lookup(32'hAAAA_AAAA);
      send_insert(32'hFFFF_FFFF, 6'd32);
      send_insert(32'h8000_0000, 6'd1);
      send_lookup(32'h8000_0000);
      send_insert(32'h7FFF_FFFF, 6'd33);
      send_lookup(32'h7FFF_FFFF);
      send_clear();

      while (items_sent < ITEM_GOAL) begin
         idle_enabled = ($urandom_range(0, 3) != 0);
         if ($urandom_range(0, 3) == 0) begin
            // Fill the pool with a run of full-length prefixes to drain it, then
            // squeeze shorter ones into what is left.
            send_clear();
            repeat (36) begin
               send_insert($urandom, 6'd32);
               if ($urandom_range(0, 1)) send_lookup(near_addr());
            end
            for (p = 31; p >= 1; p--) begin
               send_insert($urandom_range(0, 1) ? near_addr() : $urandom, 6'(p));
            end
            repeat (6) send_lookup(near_addr());
            if ($urandom_range(0, 1)) send_insert($urandom, 6'd0);
            repeat (4) send_lookup($urandom);
         end else begin
            if ($urandom_range(0, 1)) send_clear();
            repeat ($urandom_range(20, 40)) begin
               r = $urandom_range(0, 99);
               if (r < 45) begin
                  p = $urandom_range(0, 99);
                  if (p < 3)
                     p = 0;
                  else if (p < 8)
                     p = $urandom_range(33, 63);
                  else
                     p = $urandom_range(1, 32);
                  send_insert($urandom_range(0, 1) ? near_addr() : $urandom, 6'(p));
               end else if (r < 93) begin
                  send_lookup(near_addr());
               end else if (r < 96) begin
                  send_clear();
               end else begin
                  send_lookup($urandom);
               end
            end
         end
      end

      @(negedge clock);
      start <= 1'b0;
      while (outstanding != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (failures == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

### sim.f
hdl/iptf_pkg.sv
hdl/iptf_ram.sv
hdl/iptf_ctrl.sv
hdl/iptf_datapath.sv
hdl/ipv4_prefix_trie_filter_unit.sv
bench/iptf_result_checker.sv
bench/ipv4_prefix_trie_filter_unit_tb.sv
